FILE: design/plob_pkg.sv
// ----------------------------------------------------------------------------
// plob_pkg
// Shared types and constants for the price-level order book.
// ----------------------------------------------------------------------------
package plob_pkg;

   localparam int unsigned LEVELS_DEFAULT = 64;
   localparam int unsigned DATA_W         = 32;
   localparam int unsigned COUNT_OUT_W    = 7;

   // request encodings
   localparam logic KIND_ADD = 1'b0;
   localparam logic KIND_DEL = 1'b1;
   localparam logic SIDE_BID = 1'b0;
   localparam logic SIDE_ASK = 1'b1;

   typedef enum logic [2:0] {
      ST_NEW      = 3'd0,
      ST_ACC      = 3'd1,
      ST_REMOVED  = 3'd2,
      ST_REDUCED  = 3'd3,
      ST_NOTFOUND = 3'd4,
      ST_FULL     = 3'd5
   } status_type;

   // sequencer to one side's chain
   typedef struct packed {
      logic cmp_en;   // cells latch their compare flags
      logic upd_en;   // cells apply the update
      logic sel;      // this chain is the side addressed
      logic del;      // delete rather than add
   } ctl_type;

   // chain to each cell during the update cycle
   typedef struct packed {
      logic ins;
      logic rem;
      logic acc;
      logic red;
   } op_type;

endpackage

FILE: design/plob_cell.sv
// ----------------------------------------------------------------------------
// plob_cell
// One price level of a sorted chain: holds price and volume, compares them
// against the request and shifts to or from its neighbors on an update.
// ----------------------------------------------------------------------------
module plob_cell (
   input  logic                          clock,
   input  logic                          cmp_en,
   input  plob_pkg::op_type              op,
   input  logic                          valid,
   input  logic                          is_ask,
   input  logic [plob_pkg::DATA_W-1:0]   req_price,
   input  logic [plob_pkg::DATA_W-1:0]   req_volume,
   input  logic                          prev_better,
   input  logic [plob_pkg::DATA_W-1:0]   left_price,
   input  logic [plob_pkg::DATA_W-1:0]   left_volume,
   input  logic [plob_pkg::DATA_W-1:0]   right_price,
   input  logic [plob_pkg::DATA_W-1:0]   right_volume,
   output logic [plob_pkg::DATA_W-1:0]   price,
   output logic [plob_pkg::DATA_W-1:0]   volume,
   output logic                          better,
   output logic                          match,
   output logic                          less
);

   logic [plob_pkg::DATA_W-1:0] price_ff, price_in;
   logic [plob_pkg::DATA_W-1:0] volume_ff, volume_in;
   logic                        better_ff, better_in;
   logic                        match_ff, match_in;
   logic                        less_ff, less_in;
   logic [plob_pkg::DATA_W:0]   sum;

   assign sum = {1'b0, volume_ff} + {1'b0, req_volume};

   always_comb begin
      better_in = better_ff;
      match_in  = match_ff;
      less_in   = less_ff;
      if (cmp_en) begin
         // an empty slot is never better, so it ends the sorted prefix
         better_in = valid && (is_ask ? (price_ff < req_price) : (price_ff > req_price));
         match_in  = valid && (price_ff == req_price);
         less_in   = req_volume < volume_ff;
      end
   end

   always_comb begin
      price_in  = price_ff;
      volume_in = volume_ff;
      if (op.ins && !better_ff) begin
         if (prev_better) begin
            price_in  = req_price;
            volume_in = req_volume;
         end else begin
            price_in  = left_price;
            volume_in = left_volume;
         end
      end else if (op.rem && !better_ff) begin
         price_in  = right_price;
         volume_in = right_volume;
      end else if (op.acc && match_ff) begin
         volume_in = sum[plob_pkg::DATA_W] ? '1 : sum[plob_pkg::DATA_W-1:0];
      end else if (op.red && match_ff) begin
         volume_in = volume_ff - req_volume;
      end
   end

   always_ff @(posedge clock) begin
      price_ff  <= price_in;
      volume_ff <= volume_in;
      better_ff <= better_in;
      match_ff  <= match_in;
      less_ff   <= less_in;
   end

   assign price  = price_ff;
   assign volume = volume_ff;
   assign better = better_ff;
   assign match  = match_ff;
   assign less   = less_ff;

endmodule

FILE: design/plob_chain.sv
// ----------------------------------------------------------------------------
// plob_chain
// One side of the book: a row of level cells kept best-first, plus the
// level count and the status decision for that side.
// ----------------------------------------------------------------------------
module plob_chain #(
   parameter int unsigned LEVELS = plob_pkg::LEVELS_DEFAULT,
   parameter bit          IS_ASK = 1'b0,
   localparam int unsigned CNT_W = $clog2(LEVELS + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  plob_pkg::ctl_type             ctl,
   input  logic [plob_pkg::DATA_W-1:0]   req_price,
   input  logic [plob_pkg::DATA_W-1:0]   req_volume,
   output plob_pkg::status_type          status,
   output logic                          best_valid,
   output logic [plob_pkg::DATA_W-1:0]   best_price,
   output logic [plob_pkg::DATA_W-1:0]   best_volume,
   output logic [CNT_W-1:0]              count
);

   logic [CNT_W-1:0]            count_ff, count_in;
   logic [plob_pkg::DATA_W-1:0] price_w  [LEVELS];
   logic [plob_pkg::DATA_W-1:0] volume_w [LEVELS];
   logic [LEVELS-1:0]           better_w;
   logic [LEVELS-1:0]           match_w;
   logic [LEVELS-1:0]           less_w;
   logic                        found;
   logic                        hit_less;
   logic                        full;
   plob_pkg::op_type            op;

   for (genvar k = 0; k < LEVELS; k++) begin : g_cell
      logic                        prev_better;
      logic [plob_pkg::DATA_W-1:0] left_price, left_volume;
      logic [plob_pkg::DATA_W-1:0] right_price, right_volume;

      if (k == 0) begin : g_head
         assign prev_better = 1'b1;
         assign left_price  = '0;
         assign left_volume = '0;
      end else begin : g_body
         assign prev_better = better_w[k-1];
         assign left_price  = price_w[k-1];
         assign left_volume = volume_w[k-1];
      end

      if (k == LEVELS - 1) begin : g_tail
         assign right_price  = '0;
         assign right_volume = '0;
      end else begin : g_mid
         assign right_price  = price_w[k+1];
         assign right_volume = volume_w[k+1];
      end

      plob_cell u_cell (
         .clock        (clock),
         .cmp_en       (ctl.cmp_en),
         .op           (op),
         .valid        (count_ff > CNT_W'(k)),
         .is_ask       (IS_ASK),
         .req_price    (req_price),
         .req_volume   (req_volume),
         .prev_better  (prev_better),
         .left_price   (left_price),
         .left_volume  (left_volume),
         .right_price  (right_price),
         .right_volume (right_volume),
         .price        (price_w[k]),
         .volume       (volume_w[k]),
         .better       (better_w[k]),
         .match        (match_w[k]),
         .less         (less_w[k])
      );
   end

   // at most one cell can match, the table being strictly sorted
   assign found    = |match_w;
   assign hit_less = |(match_w & less_w);
   assign full     = (count_ff == CNT_W'(LEVELS));

   always_comb begin
      op.ins = ctl.upd_en && ctl.sel && (ctl.del == plob_pkg::KIND_ADD) && !found && !full;
      op.acc = ctl.upd_en && ctl.sel && (ctl.del == plob_pkg::KIND_ADD) && found;
      op.red = ctl.upd_en && ctl.sel && (ctl.del == plob_pkg::KIND_DEL) && found && hit_less;
      op.rem = ctl.upd_en && ctl.sel && (ctl.del == plob_pkg::KIND_DEL) && found && !hit_less;
   end

   always_comb begin
      count_in = count_ff;
      if (op.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (op.rem) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      if (ctl.del == plob_pkg::KIND_ADD) begin
         status = found ? plob_pkg::ST_ACC : (full ? plob_pkg::ST_FULL : plob_pkg::ST_NEW);
      end else begin
         status = !found ? plob_pkg::ST_NOTFOUND
                         : (hit_less ? plob_pkg::ST_REDUCED : plob_pkg::ST_REMOVED);
      end
   end

   assign best_valid  = (count_ff != '0);
   assign best_price  = best_valid ? price_w[0]  : '0;
   assign best_volume = best_valid ? volume_w[0] : '0;
   assign count       = count_ff;

endmodule

FILE: design/price_level_order_book.sv
// ----------------------------------------------------------------------------
// price_level_order_book
// Bid and ask price-level tables, each a sorted chain of level cells.
// Adds accumulate or, space permitting, insert a level; deletes reduce or remove one.
// ----------------------------------------------------------------------------
//   channel | prefix | direction | payload
//   --------+--------+-----------+------------------------------------------
//   request | req_   | in        | kind, side, price, volume
//   result  | rsp_   | out       | status, best bid/ask price+volume, counts
//
// A transaction runs a compare cycle in which every cell of the chain checks
// its level against the price, an update cycle in which the cells shift or
// adjust in place, and a cycle loading the result register. The next request
// is taken in that result cycle if the result register is free, or when idle.
// Synchronous reset empties both tables and stalls requests; the cells hold no
// reset. A stalled result holds the result register until it drains.
// ----------------------------------------------------------------------------
module price_level_order_book #(
   parameter int unsigned LEVELS = plob_pkg::LEVELS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_kind,
   input  logic                                req_side,
   input  logic [plob_pkg::DATA_W-1:0]         req_price,
   input  logic [plob_pkg::DATA_W-1:0]         req_volume,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [2:0]                          rsp_status,
   output logic                                rsp_bid_valid,
   output logic [plob_pkg::DATA_W-1:0]         rsp_best_bid_price,
   output logic [plob_pkg::DATA_W-1:0]         rsp_best_bid_volume,
   output logic                                rsp_ask_valid,
   output logic [plob_pkg::DATA_W-1:0]         rsp_best_ask_price,
   output logic [plob_pkg::DATA_W-1:0]         rsp_best_ask_volume,
   output logic [plob_pkg::COUNT_OUT_W-1:0]    rsp_bid_count,
   output logic [plob_pkg::COUNT_OUT_W-1:0]    rsp_ask_count
);

   localparam int unsigned CNT_W = $clog2(LEVELS + 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_CMP  = 4'b0010,
      S_UPD  = 4'b0100,
      S_RESP = 4'b1000
   } state_type;

   state_type                         state_ff, state_in;
   logic                              kind_ff, side_ff;
   logic [plob_pkg::DATA_W-1:0]       price_ff, volume_ff;
   plob_pkg::status_type              status_ff, status_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [2:0]                        rsp_status_ff;
   logic                              bid_valid_ff, ask_valid_ff;
   logic [plob_pkg::DATA_W-1:0]       bid_price_ff, bid_volume_ff;
   logic [plob_pkg::DATA_W-1:0]       ask_price_ff, ask_volume_ff;
   logic [plob_pkg::COUNT_OUT_W-1:0]  bid_count_ff, ask_count_ff;

   logic                              accept;
   logic                              out_free;
   logic                              load;
   plob_pkg::ctl_type                 bid_ctl, ask_ctl;
   plob_pkg::status_type              bid_status, ask_status;
   logic                              bid_valid, ask_valid;
   logic [plob_pkg::DATA_W-1:0]       bid_price, bid_volume, ask_price, ask_volume;
   logic [CNT_W-1:0]                  bid_count, ask_count;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load      = (state_ff == S_RESP) && out_free;
   assign req_stall = reset || !((state_ff == S_IDLE) || load);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      bid_ctl.cmp_en = (state_ff == S_CMP);
      bid_ctl.upd_en = (state_ff == S_UPD);
      bid_ctl.sel    = (side_ff == plob_pkg::SIDE_BID);
      bid_ctl.del    = kind_ff;
      ask_ctl        = bid_ctl;
      ask_ctl.sel    = (side_ff == plob_pkg::SIDE_ASK);
   end

   plob_chain #(.LEVELS(LEVELS), .IS_ASK(1'b0)) u_bid (
      .clock       (clock),
      .reset       (reset),
      .ctl         (bid_ctl),
      .req_price   (price_ff),
      .req_volume  (volume_ff),
      .status      (bid_status),
      .best_valid  (bid_valid),
      .best_price  (bid_price),
      .best_volume (bid_volume),
      .count       (bid_count)
   );

   plob_chain #(.LEVELS(LEVELS), .IS_ASK(1'b1)) u_ask (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ask_ctl),
      .req_price   (price_ff),
      .req_volume  (volume_ff),
      .status      (ask_status),
      .best_valid  (ask_valid),
      .best_price  (ask_price),
      .best_volume (ask_volume),
      .count       (ask_count)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_UPD;
         end
         S_UPD: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (accept) begin
               state_in = S_CMP;
            end else if (load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign status_in    = (side_ff == plob_pkg::SIDE_ASK) ? ask_status : bid_status;
   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= req_kind;
         side_ff   <= req_side;
         price_ff  <= req_price;
         volume_ff <= req_volume;
      end
      if (state_ff == S_UPD) begin
         status_ff <= status_in;
      end
      if (load) begin
         rsp_status_ff <= status_ff;
         bid_valid_ff  <= bid_valid;
         bid_price_ff  <= bid_price;
         bid_volume_ff <= bid_volume;
         ask_valid_ff  <= ask_valid;
         ask_price_ff  <= ask_price;
         ask_volume_ff <= ask_volume;
         bid_count_ff  <= plob_pkg::COUNT_OUT_W'(bid_count);
         ask_count_ff  <= plob_pkg::COUNT_OUT_W'(ask_count);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_bid_valid       = bid_valid_ff;
   assign rsp_best_bid_price  = bid_price_ff;
   assign rsp_best_bid_volume = bid_volume_ff;
   assign rsp_ask_valid       = ask_valid_ff;
   assign rsp_best_ask_price  = ask_price_ff;
   assign rsp_best_ask_volume = ask_volume_ff;
   assign rsp_bid_count       = bid_count_ff;
   assign rsp_ask_count       = ask_count_ff;

endmodule

FILE: design/plob_checker.sv
// ----------------------------------------------------------------------------
// plob_checker
// Port-level checks for the order book, bound onto the top level.
// ----------------------------------------------------------------------------
module plob_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [2:0]                          rsp_status,
   input logic                                rsp_bid_valid,
   input logic [plob_pkg::DATA_W-1:0]         rsp_best_bid_price,
   input logic [plob_pkg::DATA_W-1:0]         rsp_best_bid_volume,
   input logic                                rsp_ask_valid,
   input logic [plob_pkg::DATA_W-1:0]         rsp_best_ask_price,
   input logic [plob_pkg::DATA_W-1:0]         rsp_best_ask_volume,
   input logic [plob_pkg::COUNT_OUT_W-1:0]    rsp_bid_count,
   input logic [plob_pkg::COUNT_OUT_W-1:0]    rsp_ask_count
);

   // compare and update cycles follow every accepted transaction
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall ##1 req_stall)
      else $error("request taken during compare or update");

   // an empty bid side reports zero price, volume and count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bid_valid |->
         rsp_best_bid_price == '0 && rsp_best_bid_volume == '0 && rsp_bid_count == '0)
      else $error("empty bid side shows data");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ask_valid |->
         rsp_best_ask_price == '0 && rsp_best_ask_volume == '0 && rsp_ask_count == '0)
      else $error("empty ask side shows data");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_bid_count) && $stable(rsp_ask_count))
      else $error("stalled result changed");

endmodule

bind price_level_order_book plob_checker u_plob_checker (.*);
